// ===== design/abb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abb_pkg
// Shared types, constants and the quarter-wave sine table for the arc
// bounding box unit.
// ----------------------------------------------------------------------------
package abb_pkg;

  localparam int SINE_FRACTION_BITS   = 16;
  localparam int ANGLE_STEPS_PER_TURN = 5760;
  localparam int QUARTER_STEPS        = ANGLE_STEPS_PER_TURN / 4;
  localparam int HALF_TURN_STEPS      = ANGLE_STEPS_PER_TURN / 2;

  localparam int COORD_W    = 16;
  localparam int RADIUS_W   = 14;
  localparam int ANGLE_W    = 14;
  localparam int BOX_POS_W  = COORD_W + 1;
  localparam int BOX_SIZE_W = 15;
  localparam int REDUCED_W  = $clog2(ANGLE_STEPS_PER_TURN);
  localparam int SINE_W     = SINE_FRACTION_BITS + 1;
  localparam int ROM_DEPTH  = QUARTER_STEPS + 1;
  localparam int ROM_AW     = $clog2(ROM_DEPTH);
  localparam int PROD_W     = RADIUS_W + SINE_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef logic        [ANGLE_W-1:0]    angle_t;
  typedef logic        [REDUCED_W-1:0]  reduced_t;
  typedef logic        [ROM_AW-1:0]     rom_addr_t;
  typedef logic        [SINE_W-1:0]     sine_t;
  typedef sine_t                        sine_rom_t [ROM_DEPTH];
  typedef logic        [RADIUS_W-1:0]   radius_t;
  typedef logic signed [COORD_W-1:0]    coord_t;
  typedef logic signed [BOX_POS_W-1:0]  box_pos_t;
  typedef logic        [BOX_SIZE_W-1:0] box_size_t;
  typedef logic        [PROD_W-1:0]     prod_t;
  typedef logic        [QUEUE_AW-1:0]   queue_ptr_t;
  typedef logic        [QUEUE_AW:0]     queue_cnt_t;

  localparam angle_t    ONE_TURN     = angle_t'(ANGLE_STEPS_PER_TURN);
  localparam angle_t    TWO_TURNS    = angle_t'(2 * ANGLE_STEPS_PER_TURN);
  localparam reduced_t  AXIS_90      = reduced_t'(QUARTER_STEPS);
  localparam reduced_t  AXIS_180     = reduced_t'(2 * QUARTER_STEPS);
  localparam reduced_t  AXIS_270     = reduced_t'(3 * QUARTER_STEPS);
  localparam angle_t    AXIS_90_WRAP  = angle_t'(QUARTER_STEPS + ANGLE_STEPS_PER_TURN);
  localparam angle_t    AXIS_180_WRAP = angle_t'(2 * QUARTER_STEPS + ANGLE_STEPS_PER_TURN);
  localparam angle_t    AXIS_270_WRAP = angle_t'(3 * QUARTER_STEPS + ANGLE_STEPS_PER_TURN);
  localparam rom_addr_t QUARTER_ADDR = rom_addr_t'(QUARTER_STEPS);
  localparam queue_cnt_t QUEUE_FULL  = queue_cnt_t'(QUEUE_DEPTH);

  localparam box_pos_t  BOX_POS_FLOOR = {1'b1, {(BOX_POS_W-1){1'b0}}};
  localparam box_size_t BOX_SIZE_TOP  = '1;

  typedef struct packed {
    rom_addr_t addr;
    logic      neg;
  } lookup_t;

  typedef struct packed {
    logic top_edge;
    logic left_edge;
    logic bottom_edge;
    logic right_edge;
  } edge_t;

  typedef struct packed {
    coord_t  center_x;
    coord_t  center_y;
    radius_t radius;
    edge_t   edges;
    lookup_t sin_b;
    lookup_t cos_b;
    lookup_t sin_e;
    lookup_t cos_e;
  } job_t;

  // Taylor series in Q30, evaluated at elaboration only.
  function automatic sine_t quarter_sine(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] one;
    x   = (64'(k) * PI_Q30 + 64'(HALF_TURN_STEPS / 2)) / 64'(HALF_TURN_STEPS);
    x2  = (x * x) >> 30;
    t   = x;
    pos = x;
    neg = '0;
    t = ((t * x2) >> 30) / 64'd6;   neg = neg + t;
    t = ((t * x2) >> 30) / 64'd20;  pos = pos + t;
    t = ((t * x2) >> 30) / 64'd42;  neg = neg + t;
    t = ((t * x2) >> 30) / 64'd72;  pos = pos + t;
    t = ((t * x2) >> 30) / 64'd110; neg = neg + t;
    t = ((t * x2) >> 30) / 64'd156; pos = pos + t;
    t = ((t * x2) >> 30) / 64'd210; neg = neg + t;
    t = ((t * x2) >> 30) / 64'd272; pos = pos + t;
    s   = (pos > neg) ? pos - neg : '0;
    s   = (s + (64'd1 << (29 - SINE_FRACTION_BITS))) >> (30 - SINE_FRACTION_BITS);
    one = 64'd1 << SINE_FRACTION_BITS;
    if (s > one) begin
      s = one;
    end
    return sine_t'(s);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      rom[k] = quarter_sine(k);
    end
    return rom;
  endfunction

endpackage

// ===== design/abb_arc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abb_arc_if
// Arc input channel: valid/ready handshake with center, radius and angles.
// ----------------------------------------------------------------------------
interface abb_arc_if;
  logic              valid;
  logic              ready;
  abb_pkg::coord_t   center_x;
  abb_pkg::coord_t   center_y;
  abb_pkg::radius_t  radius;
  abb_pkg::angle_t   start_angle;
  abb_pkg::angle_t   stop_angle;

  modport source (output valid, center_x, center_y, radius, start_angle, stop_angle,
                  input ready);
  modport sink   (input valid, center_x, center_y, radius, start_angle, stop_angle,
                  output ready);
endinterface

// ===== design/abb_box_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abb_box_if
// Box result channel: valid/ready handshake with left, top, width, height.
// ----------------------------------------------------------------------------
interface abb_box_if;
  logic                valid;
  logic                ready;
  abb_pkg::box_pos_t   box_left;
  abb_pkg::box_pos_t   box_top;
  abb_pkg::box_size_t  box_width;
  abb_pkg::box_size_t  box_height;

  modport source (output valid, box_left, box_top, box_width, box_height, input ready);
  modport sink   (input valid, box_left, box_top, box_width, box_height, output ready);
endinterface

// ===== design/abb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abb_front
// Takes arc beats, reduces both angles to one turn, then classifies the arc:
// axis edges reached and sine/cosine table addresses with quadrant signs.
// ----------------------------------------------------------------------------
module abb_front (
  input  logic          clk,
  input  logic          rst,
  abb_arc_if.sink       arc,
  output abb_pkg::job_t job,
  output logic          job_valid,
  input  logic          job_ready
);

  typedef struct packed {
    abb_pkg::lookup_t sin_l;
    abb_pkg::lookup_t cos_l;
  } angle_lookup_t;

  function automatic abb_pkg::reduced_t reduce_angle(input abb_pkg::angle_t a);
    abb_pkg::angle_t r;
    if (a >= abb_pkg::TWO_TURNS) begin
      r = a - abb_pkg::TWO_TURNS;
    end else if (a >= abb_pkg::ONE_TURN) begin
      r = a - abb_pkg::ONE_TURN;
    end else begin
      r = a;
    end
    return abb_pkg::reduced_t'(r);
  endfunction

  function automatic angle_lookup_t angle_lookup(input abb_pkg::reduced_t a);
    logic [1:0]         q;
    abb_pkg::reduced_t  r_full;
    abb_pkg::rom_addr_t r;
    angle_lookup_t      l;
    if (a >= abb_pkg::AXIS_270) begin
      q      = 2'd3;
      r_full = a - abb_pkg::AXIS_270;
    end else if (a >= abb_pkg::AXIS_180) begin
      q      = 2'd2;
      r_full = a - abb_pkg::AXIS_180;
    end else if (a >= abb_pkg::AXIS_90) begin
      q      = 2'd1;
      r_full = a - abb_pkg::AXIS_90;
    end else begin
      q      = 2'd0;
      r_full = a;
    end
    r            = abb_pkg::rom_addr_t'(r_full);
    l.sin_l.addr = q[0] ? abb_pkg::QUARTER_ADDR - r : r;
    l.sin_l.neg  = q[1];
    l.cos_l.addr = q[0] ? r : abb_pkg::QUARTER_ADDR - r;
    l.cos_l.neg  = q[0] ^ q[1];
    return l;
  endfunction

  function automatic logic crosses(input abb_pkg::reduced_t b, input abb_pkg::angle_t ne,
                                   input abb_pkg::reduced_t axis,
                                   input abb_pkg::angle_t axis_wrap);
    return ((b <= axis) && (ne >= abb_pkg::angle_t'(axis))) || (ne >= axis_wrap);
  endfunction

  logic              f1_valid;
  abb_pkg::coord_t   f1_cx;
  abb_pkg::coord_t   f1_cy;
  abb_pkg::radius_t  f1_rad;
  abb_pkg::reduced_t f1_b;
  abb_pkg::reduced_t f1_e;

  logic              f1_ready;
  logic              equal_ang;
  logic              wrap;
  abb_pkg::angle_t   ne;
  angle_lookup_t     lk_b;
  angle_lookup_t     lk_e;

  assign f1_ready  = !f1_valid || job_ready;
  assign arc.ready = f1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (f1_ready) begin
      f1_valid <= arc.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_ready && arc.valid) begin
      f1_cx  <= arc.center_x;
      f1_cy  <= arc.center_y;
      f1_rad <= arc.radius;
      f1_b   <= reduce_angle(arc.start_angle);
      f1_e   <= reduce_angle(arc.stop_angle);
    end
  end

  always_comb begin
    equal_ang = (f1_b == f1_e);
    wrap      = (f1_b > f1_e);
    ne        = wrap ? abb_pkg::angle_t'(f1_e) + abb_pkg::ONE_TURN : abb_pkg::angle_t'(f1_e);
    lk_b      = angle_lookup(f1_b);
    lk_e      = angle_lookup(f1_e);

    job.center_x          = f1_cx;
    job.center_y          = f1_cy;
    job.radius            = f1_rad;
    job.edges.top_edge    = equal_ang ||
                            crosses(f1_b, ne, abb_pkg::AXIS_90, abb_pkg::AXIS_90_WRAP);
    job.edges.left_edge   = equal_ang ||
                            crosses(f1_b, ne, abb_pkg::AXIS_180, abb_pkg::AXIS_180_WRAP);
    job.edges.bottom_edge = equal_ang ||
                            crosses(f1_b, ne, abb_pkg::AXIS_270, abb_pkg::AXIS_270_WRAP);
    job.edges.right_edge  = equal_ang || wrap;
    job.sin_b             = lk_b.sin_l;
    job.cos_b             = lk_b.cos_l;
    job.sin_e             = lk_e.sin_l;
    job.cos_e             = lk_e.cos_l;
  end

  assign job_valid = f1_valid;

endmodule

// ===== design/abb_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abb_queue
// Small FIFO of classified arcs between the front and back sections.
// ----------------------------------------------------------------------------
module abb_queue (
  input  logic          clk,
  input  logic          rst,
  input  abb_pkg::job_t in_job,
  input  logic          in_valid,
  output logic          in_ready,
  output abb_pkg::job_t out_job,
  output logic          out_valid,
  input  logic          out_ready
);

  abb_pkg::job_t       mem [abb_pkg::QUEUE_DEPTH];
  abb_pkg::queue_ptr_t wr_ptr;
  abb_pkg::queue_ptr_t rd_ptr;
  abb_pkg::queue_cnt_t count;
  abb_pkg::queue_cnt_t count_next;
  logic                push;
  logic                pop;

  assign in_ready  = (count != abb_pkg::QUEUE_FULL);
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_job   = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_job;
    end
  end

endmodule

// ===== design/abb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abb_back
// Sine table reads, radius products, endpoint coordinates, edge selection
// and the output register. The whole section advances together.
// ----------------------------------------------------------------------------
module abb_back (
  input  logic          clk,
  input  logic          rst,
  input  abb_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_ready,
  abb_box_if.source     box
);

  localparam abb_pkg::sine_rom_t SineRomB = abb_pkg::build_sine_rom();
  localparam abb_pkg::sine_rom_t SineRomE = abb_pkg::build_sine_rom();

  function automatic abb_pkg::box_pos_t ext_coord(input abb_pkg::coord_t c);
    return {c[abb_pkg::COORD_W-1], c};
  endfunction

  function automatic abb_pkg::box_pos_t ext_radius(input abb_pkg::radius_t r);
    return {{(abb_pkg::BOX_POS_W-abb_pkg::RADIUS_W){1'b0}}, r};
  endfunction

  function automatic abb_pkg::radius_t scale(input abb_pkg::radius_t r,
                                             input abb_pkg::sine_t s);
    abb_pkg::prod_t p;
    p = abb_pkg::prod_t'(r) * abb_pkg::prod_t'(s);
    return p[abb_pkg::SINE_FRACTION_BITS +: abb_pkg::RADIUS_W];
  endfunction

  function automatic abb_pkg::box_pos_t apply_sign(input abb_pkg::radius_t m,
                                                   input logic neg);
    abb_pkg::box_pos_t v;
    v = ext_radius(m);
    return neg ? -v : v;
  endfunction

  logic adv;

  // stage 1: table read
  logic              s1_valid;
  abb_pkg::coord_t   s1_cx;
  abb_pkg::coord_t   s1_cy;
  abb_pkg::radius_t  s1_rad;
  abb_pkg::edge_t    s1_edges;
  logic [3:0]        s1_neg;
  abb_pkg::sine_t    s1_sin_b;
  abb_pkg::sine_t    s1_cos_b;
  abb_pkg::sine_t    s1_sin_e;
  abb_pkg::sine_t    s1_cos_e;

  // stage 2: products
  logic              s2_valid;
  abb_pkg::coord_t   s2_cx;
  abb_pkg::coord_t   s2_cy;
  abb_pkg::radius_t  s2_rad;
  abb_pkg::edge_t    s2_edges;
  logic [3:0]        s2_neg;
  abb_pkg::radius_t  s2_sin_b;
  abb_pkg::radius_t  s2_cos_b;
  abb_pkg::radius_t  s2_sin_e;
  abb_pkg::radius_t  s2_cos_e;

  // stage 3: endpoints and circle extremes
  logic              s3_valid;
  abb_pkg::edge_t    s3_edges;
  abb_pkg::box_pos_t s3_xb;
  abb_pkg::box_pos_t s3_yb;
  abb_pkg::box_pos_t s3_xe;
  abb_pkg::box_pos_t s3_ye;
  abb_pkg::box_pos_t s3_ext_l;
  abb_pkg::box_pos_t s3_ext_r;
  abb_pkg::box_pos_t s3_ext_t;
  abb_pkg::box_pos_t s3_ext_bt;

  // stage 4: box sides
  logic              s4_valid;
  abb_pkg::box_pos_t s4_l;
  abb_pkg::box_pos_t s4_r;
  abb_pkg::box_pos_t s4_t;
  abb_pkg::box_pos_t s4_bt;
  abb_pkg::box_pos_t s4_width;
  abb_pkg::box_pos_t s4_height;

  assign adv       = !box.valid || box.ready;
  assign job_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      box.valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= job_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      box.valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cx    <= job.center_x;
      s1_cy    <= job.center_y;
      s1_rad   <= job.radius;
      s1_edges <= job.edges;
      s1_neg   <= {job.sin_b.neg, job.cos_b.neg, job.sin_e.neg, job.cos_e.neg};
      s1_sin_b <= SineRomB[job.sin_b.addr];
      s1_cos_b <= SineRomB[job.cos_b.addr];
      s1_sin_e <= SineRomE[job.sin_e.addr];
      s1_cos_e <= SineRomE[job.cos_e.addr];

      s2_cx    <= s1_cx;
      s2_cy    <= s1_cy;
      s2_rad   <= s1_rad;
      s2_edges <= s1_edges;
      s2_neg   <= s1_neg;
      s2_sin_b <= scale(s1_rad, s1_sin_b);
      s2_cos_b <= scale(s1_rad, s1_cos_b);
      s2_sin_e <= scale(s1_rad, s1_sin_e);
      s2_cos_e <= scale(s1_rad, s1_cos_e);

      s3_edges  <= s2_edges;
      s3_xb     <= ext_coord(s2_cx) + apply_sign(s2_cos_b, s2_neg[2]);
      s3_yb     <= ext_coord(s2_cy) - apply_sign(s2_sin_b, s2_neg[3]);
      s3_xe     <= ext_coord(s2_cx) + apply_sign(s2_cos_e, s2_neg[0]);
      s3_ye     <= ext_coord(s2_cy) - apply_sign(s2_sin_e, s2_neg[1]);
      s3_ext_l  <= ext_coord(s2_cx) - ext_radius(s2_rad);
      s3_ext_r  <= ext_coord(s2_cx) + ext_radius(s2_rad);
      s3_ext_t  <= ext_coord(s2_cy) - ext_radius(s2_rad);
      s3_ext_bt <= ext_coord(s2_cy) + ext_radius(s2_rad);

      s4_l  <= s3_edges.left_edge   ? s3_ext_l  : ((s3_xb < s3_xe) ? s3_xb : s3_xe);
      s4_r  <= s3_edges.right_edge  ? s3_ext_r  : ((s3_xb > s3_xe) ? s3_xb : s3_xe);
      s4_t  <= s3_edges.top_edge    ? s3_ext_t  : ((s3_yb < s3_ye) ? s3_yb : s3_ye);
      s4_bt <= s3_edges.bottom_edge ? s3_ext_bt : ((s3_yb > s3_ye) ? s3_yb : s3_ye);

      box.box_left   <= s4_l;
      box.box_top    <= s4_t;
      box.box_width  <= s4_width[abb_pkg::BOX_SIZE_W-1:0];
      box.box_height <= s4_height[abb_pkg::BOX_SIZE_W-1:0];
    end
  end

  assign s4_width  = s4_r - s4_l;
  assign s4_height = s4_bt - s4_t;

endmodule

// ===== design/arc_bounding_box_unit.sv =====
// Each arc beat passes the front register, the queue, the back stages and the output register.
// Throughput: one arc per cycle while the box side keeps taking beats.
// A 4-entry queue lets the arc side keep going for a few beats under stall.
// Reset clears all valid flags and the queue; no table init pass.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_bounding_box_unit
// Axis-aligned bounding box of a circular arc given in 1/16 degree steps.
// ----------------------------------------------------------------------------
module arc_bounding_box_unit (
  input  logic      clk,
  input  logic      rst,
  abb_arc_if.sink   arc,
  abb_box_if.source box
);

  abb_pkg::job_t front_job;
  logic          front_valid;
  logic          front_ready;
  abb_pkg::job_t back_job;
  logic          back_valid;
  logic          back_ready;

  abb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .arc       (arc),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  abb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_job    (front_job),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .out_job   (back_job),
    .out_valid (back_valid),
    .out_ready (back_ready)
  );

  abb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .box       (box)
  );

endmodule

// ===== design/abb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abb_checker
// Port-level checks on the box channel of the arc bounding box unit.
// ----------------------------------------------------------------------------
module abb_checker (
  input logic               clk,
  input logic               rst,
  input logic               box_valid,
  input logic               box_ready,
  input abb_pkg::box_pos_t  box_left,
  input abb_pkg::box_pos_t  box_top,
  input abb_pkg::box_size_t box_width,
  input abb_pkg::box_size_t box_height
);

  a_reset_clears_box: assert property (@(posedge clk) rst |=> !box_valid)
    else $error("box valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    box_valid && !box_ready |=> box_valid && $stable(box_left) && $stable(box_top) &&
      $stable(box_width) && $stable(box_height))
    else $error("stalled box beat changed");

  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    box_valid |-> (box_width != abb_pkg::BOX_SIZE_TOP) &&
      (box_height != abb_pkg::BOX_SIZE_TOP))
    else $error("box size beyond twice the radius range");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    box_valid |-> (box_left != abb_pkg::BOX_POS_FLOOR) &&
      (box_top != abb_pkg::BOX_POS_FLOOR))
    else $error("box corner beyond coordinate range");

endmodule

bind arc_bounding_box_unit abb_checker u_abb_checker (
  .clk        (clk),
  .rst        (rst),
  .box_valid  (box.valid),
  .box_ready  (box.ready),
  .box_left   (box.box_left),
  .box_top    (box.box_top),
  .box_width  (box.box_width),
  .box_height (box.box_height)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for arc_bounding_box_unit. It sends directed arcs
// (axis hits, wraps past 0, equal angles, out-of-range angles, zero and
// full radius), then random arcs. Both channels idle at random and the box
// side holds off for long stretches. Every box beat is checked against an
// in-bench fixed-point model of the arc box.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ARCS  = 850;
  localparam int TAIL_CYCLES  = 12;
  localparam int LONG_HOLD    = 80;

  typedef struct packed {
    abb_pkg::coord_t  center_x;
    abb_pkg::coord_t  center_y;
    abb_pkg::radius_t radius;
    abb_pkg::angle_t  start_angle;
    abb_pkg::angle_t  stop_angle;
  } arc_beat_t;

  typedef struct packed {
    abb_pkg::box_pos_t  box_left;
    abb_pkg::box_pos_t  box_top;
    abb_pkg::box_size_t box_width;
    abb_pkg::box_size_t box_height;
  } box_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  abb_arc_if arc_ch ();
  abb_box_if box_ch ();

  arc_bounding_box_unit i_dut (
    .clk (clk),
    .rst (rst),
    .arc (arc_ch),
    .box (box_ch)
  );

  always #4 clk = ~clk;

  arc_beat_t       arcs_to_send [$];
  box_beat_t       boxes_due [$];
  longint unsigned sine_q16 [0:abb_pkg::QUARTER_STEPS];

  int errors        = 0;
  int cycles        = 0;
  int arc_gap       = 0;
  int arc_quiet     = 0;
  int box_stall     = 0;
  int box_quiet     = 0;
  int boxes_checked = 0;
  int hold_left     = 0;
  int holds_done    = 0;

  // Sine of k steps in the first quadrant, Taylor series in Q30.
  function automatic longint unsigned taylor_sine_q16(int unsigned k);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term;
    longint unsigned plus_sum;
    longint unsigned minus_sum;
    longint unsigned acc;
    longint unsigned unity;
    ang       = (64'(k) * abb_pkg::PI_Q30 + 64'(abb_pkg::HALF_TURN_STEPS / 2)) /
                64'(abb_pkg::HALF_TURN_STEPS);
    ang_sq    = (ang * ang) >> 30;
    term      = ang;
    plus_sum  = ang;
    minus_sum = 0;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        minus_sum += term;
      end else begin
        plus_sum += term;
      end
    end
    acc   = (plus_sum > minus_sum) ? plus_sum - minus_sum : 64'd0;
    acc   = (acc + (64'd1 << (29 - abb_pkg::SINE_FRACTION_BITS))) >>
            (30 - abb_pkg::SINE_FRACTION_BITS);
    unity = 64'd1 << abb_pkg::SINE_FRACTION_BITS;
    return (acc > unity) ? unity : acc;
  endfunction

  // radius * sin(angle), truncated toward zero
  function automatic longint radius_times_sine(longint unsigned rad, int unsigned ang);
    int unsigned     red;
    int unsigned     quad;
    int unsigned     rem;
    longint unsigned mag;
    red  = ang % abb_pkg::ANGLE_STEPS_PER_TURN;
    quad = red / abb_pkg::QUARTER_STEPS;
    rem  = red % abb_pkg::QUARTER_STEPS;
    mag  = (quad % 2 == 1) ? sine_q16[abb_pkg::QUARTER_STEPS - rem] : sine_q16[rem];
    mag  = (rad * mag) >> abb_pkg::SINE_FRACTION_BITS;
    return (quad >= 2) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic bit passes_axis(int unsigned b, int unsigned e, int unsigned axis);
    int unsigned axis_up;
    axis_up = axis + abb_pkg::ANGLE_STEPS_PER_TURN;
    return (b <= axis && e >= axis) || (b <= axis_up && e >= axis_up);
  endfunction

  function automatic box_beat_t arc_box_of(arc_beat_t a);
    longint      cx;
    longint      cy;
    longint      rad;
    longint      left;
    longint      right;
    longint      top;
    longint      bottom;
    longint      xs;
    longint      ys;
    longint      xe;
    longint      ye;
    int unsigned b;
    int unsigned e;
    int unsigned e_lift;
    box_beat_t   bx;
    cx  = a.center_x;
    cy  = a.center_y;
    rad = a.radius;
    b   = a.start_angle % abb_pkg::ANGLE_STEPS_PER_TURN;
    e   = a.stop_angle % abb_pkg::ANGLE_STEPS_PER_TURN;
    if (b == e) begin
      left   = cx - rad;
      right  = cx + rad;
      top    = cy - rad;
      bottom = cy + rad;
    end else begin
      xs     = cx + radius_times_sine(rad, b + abb_pkg::QUARTER_STEPS);
      ys     = cy - radius_times_sine(rad, b);
      xe     = cx + radius_times_sine(rad, e + abb_pkg::QUARTER_STEPS);
      ye     = cy - radius_times_sine(rad, e);
      left   = (xs < xe) ? xs : xe;
      right  = (xs > xe) ? xs : xe;
      top    = (ys < ye) ? ys : ye;
      bottom = (ys > ye) ? ys : ye;
      e_lift = e;
      if (b > e) begin
        right  = cx + rad;
        e_lift = e + abb_pkg::ANGLE_STEPS_PER_TURN;
      end
      if (passes_axis(b, e_lift, abb_pkg::QUARTER_STEPS))     top    = cy - rad;
      if (passes_axis(b, e_lift, 2 * abb_pkg::QUARTER_STEPS)) left   = cx - rad;
      if (passes_axis(b, e_lift, 3 * abb_pkg::QUARTER_STEPS)) bottom = cy + rad;
    end
    bx.box_left   = abb_pkg::box_pos_t'(left);
    bx.box_top    = abb_pkg::box_pos_t'(top);
    bx.box_width  = abb_pkg::box_size_t'(right - left);
    bx.box_height = abb_pkg::box_size_t'(bottom - top);
    return bx;
  endfunction

  // idle cycles before the next beat, with runs of back-to-back beats
  function automatic int draw_wait(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  task automatic add_arc(int cx, int cy, int rad, int sa, int ea);
    arc_beat_t a;
    a.center_x    = abb_pkg::coord_t'(cx);
    a.center_y    = abb_pkg::coord_t'(cy);
    a.radius      = abb_pkg::radius_t'(rad);
    a.start_angle = abb_pkg::angle_t'(sa);
    a.stop_angle  = abb_pkg::angle_t'(ea);
    arcs_to_send.push_back(a);
  endtask

  function automatic int near_axis();
    return abb_pkg::QUARTER_STEPS * $urandom_range(1, 11) + $urandom_range(0, 4) - 2;
  endfunction

  // arc driver
  always @(posedge clk) begin
    if (rst) begin
      arc_ch.valid <= 1'b0;
      arc_gap = 0;
    end else begin
      if (arc_ch.valid && arc_ch.ready) begin
        boxes_due.push_back(arc_box_of(arcs_to_send.pop_front()));
        arc_gap = draw_wait(arc_quiet);
      end
      if (!arc_ch.valid || arc_ch.ready) begin
        if (arc_gap > 0) begin
          arc_gap--;
          arc_ch.valid <= 1'b0;
        end else if (arcs_to_send.size() > 0) begin
          arc_ch.valid       <= 1'b1;
          arc_ch.center_x    <= arcs_to_send[0].center_x;
          arc_ch.center_y    <= arcs_to_send[0].center_y;
          arc_ch.radius      <= arcs_to_send[0].radius;
          arc_ch.start_angle <= arcs_to_send[0].start_angle;
          arc_ch.stop_angle  <= arcs_to_send[0].stop_angle;
        end else begin
          arc_ch.valid <= 1'b0;
        end
      end
    end
  end

  // box monitor and checker
  always @(posedge clk) begin
    box_beat_t want;
    if (rst) begin
      box_ch.ready <= 1'b0;
      box_stall = 0;
    end else begin
      if (box_ch.valid && box_ch.ready) begin
        if (boxes_due.size() == 0) begin
          $error("box beat with no arc outstanding");
          errors++;
        end else begin
          want = boxes_due.pop_front();
          if (box_ch.box_left !== want.box_left) begin
            $error("box_left expected %0d got %0d", want.box_left, box_ch.box_left);
            errors++;
          end
          if (box_ch.box_top !== want.box_top) begin
            $error("box_top expected %0d got %0d", want.box_top, box_ch.box_top);
            errors++;
          end
          if (box_ch.box_width !== want.box_width) begin
            $error("box_width expected %0d got %0d", want.box_width, box_ch.box_width);
            errors++;
          end
          if (box_ch.box_height !== want.box_height) begin
            $error("box_height expected %0d got %0d", want.box_height, box_ch.box_height);
            errors++;
          end
        end
        boxes_checked <= boxes_checked + 1;
        box_stall = draw_wait(box_quiet);
      end
      if (box_stall > 0) begin
        box_stall--;
        box_ch.ready <= 1'b0;
      end else begin
        box_ch.ready <= (hold_left == 0);
      end
    end
  end

  // long hold-offs on the box side to back up the queue
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 3 && boxes_checked == 200 * (holds_done + 1)) begin
      hold_left  <= LONG_HOLD;
      holds_done <= holds_done + 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int kind;
    int sa;

    for (int k = 0; k <= abb_pkg::QUARTER_STEPS; k++) begin
      sine_q16[k] = taylor_sine_q16(k);
    end

    add_arc(0, 0, 100, 0, 0);
    add_arc(32767, 32767, 16383, 0, 0);
    add_arc(-32768, -32768, 16383, 5760, 0);
    add_arc(100, -200, 0, 0, 1440);
    add_arc(0, 0, 16383, 0, 1440);
    add_arc(0, 0, 16383, 1440, 2880);
    add_arc(0, 0, 16383, 2880, 4320);
    add_arc(0, 0, 16383, 4320, 0);
    add_arc(0, 0, 1000, 5000, 500);
    add_arc(0, 0, 1000, 100, 5700);
    add_arc(0, 0, 1000, 5700, 100);
    add_arc(-32768, 32767, 16383, 16383, 16383);
    add_arc(32767, -32768, 16383, 16383, 0);
    add_arc(0, 0, 16383, 11520, 7200);
    add_arc(1, 1, 1, 1, 2);
    add_arc(0, 0, 12345, 1439, 1441);
    add_arc(0, 0, 12345, 2879, 2881);
    add_arc(0, 0, 12345, 4319, 4321);
    add_arc(0, 0, 12345, 5759, 1);
    add_arc(-1, -1, 16383, 7200, 10080);
    add_arc(32767, 32767, 16383, 2880, 1440);
    add_arc(0, 0, 16383, 100, 99);
    add_arc(-32768, -32768, 16383, 2880, 8640);

    for (int i = 0; i < RANDOM_ARCS; i++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        5: begin
          sa = $urandom_range(0, abb_pkg::ANGLE_STEPS_PER_TURN - 1);
          add_arc($urandom, $urandom, $urandom, sa,
                  sa + abb_pkg::ANGLE_STEPS_PER_TURN * $urandom_range(0, 1));
        end
        6, 7: begin
          add_arc($urandom, $urandom, $urandom, near_axis(), near_axis());
        end
        8: begin
          add_arc($urandom, $urandom, $urandom_range(0, 3), $urandom, $urandom);
        end
        9: begin
          sa = $urandom_range(0, abb_pkg::ANGLE_STEPS_PER_TURN - 1);
          add_arc($urandom, $urandom, $urandom, sa,
                  (sa + $urandom_range(1, 200)) % abb_pkg::ANGLE_STEPS_PER_TURN);
        end
        default: begin
          add_arc($urandom, $urandom, $urandom, $urandom, $urandom);
        end
      endcase
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (arcs_to_send.size() != 0 || boxes_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== arc_bounding_box_unit.f =====
design/abb_pkg.sv
design/abb_arc_if.sv
design/abb_box_if.sv
design/abb_front.sv
design/abb_queue.sv
design/abb_back.sv
design/arc_bounding_box_unit.sv
design/abb_checker.sv
verif/tb_top.sv
